// ===== rtl/ebalu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebalu_pkg
// Shared types, operation codes and constants of the eight-bit ALU.
// ----------------------------------------------------------------------------
package ebalu_pkg;

  localparam int unsigned IN_BITS  = 28;
  localparam int unsigned OUT_BITS = 13;

  localparam logic [7:0] DAA_LIMIT   = 8'd153;
  localparam logic [7:0] DAA_ADJ_HI  = 8'd96;
  localparam logic [7:0] DAA_ADJ_LO  = 8'd6;
  localparam logic [3:0] DIGIT_LIMIT = 4'd9;

  typedef enum logic [4:0] {
    ACT_ADD  = 5'd0,
    ACT_ADC  = 5'd1,
    ACT_SUB  = 5'd2,
    ACT_SBC  = 5'd3,
    ACT_AND  = 5'd4,
    ACT_XOR  = 5'd5,
    ACT_OR   = 5'd6,
    ACT_CP   = 5'd7,
    ACT_INC  = 5'd8,
    ACT_DEC  = 5'd9,
    ACT_RLC  = 5'd10,
    ACT_RRC  = 5'd11,
    ACT_RL   = 5'd12,
    ACT_RR   = 5'd13,
    ACT_SLA  = 5'd14,
    ACT_SRA  = 5'd15,
    ACT_SWAP = 5'd16,
    ACT_SRL  = 5'd17,
    ACT_BIT  = 5'd18,
    ACT_RES  = 5'd19,
    ACT_SET  = 5'd20,
    ACT_DAA  = 5'd21,
    ACT_CPL  = 5'd22,
    ACT_SCF  = 5'd23,
    ACT_CCF  = 5'd24,
    ACT_RLCA = 5'd25,
    ACT_RRCA = 5'd26,
    ACT_RLA  = 5'd27,
    ACT_RRA  = 5'd28
  } action_t;

  // flags: z, n, h, c from the top bit down
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // packed highest-first: action in bits [4:0]
  typedef struct packed {
    flags_t     flags_in;
    logic [2:0] bit_index;
    logic [7:0] operand_value;
    logic [7:0] acc_value;
    action_t    action;
  } item_t;

  typedef struct packed {
    logic       writes_back;
    flags_t     flags_out;
    logic [7:0] result;
  } res_t;

  function automatic logic zflag(input logic [7:0] v);
    return (v == 8'd0);
  endfunction

endpackage

// ===== rtl/ebalu_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebalu_core
// Combinational datapath: result byte, flags and write-back for one item.
// ----------------------------------------------------------------------------
module ebalu_core (
  input  ebalu_pkg::item_t item,
  output ebalu_pkg::res_t  res
);

  logic [7:0] a;
  logic [7:0] v;
  logic [2:0] b;
  logic       ci;
  logic       cin;
  logic       fn;
  logic [8:0] sum9;
  logic [4:0] hsum;
  logic [8:0] dif9;
  logic [4:0] hdif;
  logic [7:0] inc_v;
  logic [7:0] dec_v;
  logic [7:0] bmask;
  logic [7:0] daa_adj;
  logic       daa_c;
  logic [7:0] daa_r;
  logic [7:0] sh_r;
  logic       sh_c;

  assign a   = item.acc_value;
  assign v   = item.operand_value;
  assign b   = item.bit_index;
  assign cin = item.flags_in.c;
  assign fn  = item.flags_in.n;
  assign ci  = ((item.action == ebalu_pkg::ACT_ADC) || (item.action == ebalu_pkg::ACT_SBC))
               ? cin : 1'b0;

  assign sum9  = {1'b0, a} + {1'b0, v} + {8'd0, ci};
  assign hsum  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, ci};
  assign dif9  = {1'b0, a} - {1'b0, v} - {8'd0, ci};
  assign hdif  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, ci};
  assign inc_v = v + 8'd1;
  assign dec_v = v - 8'd1;
  assign bmask = 8'd1 << b;

  always_comb begin
    daa_adj = 8'd0;
    daa_c   = 1'b0;
    if (item.flags_in.h || (!fn && (a[3:0] > ebalu_pkg::DIGIT_LIMIT))) begin
      daa_adj = ebalu_pkg::DAA_ADJ_LO;
    end
    if (cin || (!fn && (a > ebalu_pkg::DAA_LIMIT))) begin
      daa_adj = daa_adj | ebalu_pkg::DAA_ADJ_HI;
      daa_c   = 1'b1;
    end
    daa_r = fn ? (a - daa_adj) : (a + daa_adj);
  end

  // rotates and shifts, accumulator forms share the prefixed ones
  always_comb begin
    case (item.action)
      ebalu_pkg::ACT_RLC, ebalu_pkg::ACT_RLCA: begin
        sh_c = v[7];
        sh_r = {v[6:0], v[7]};
      end
      ebalu_pkg::ACT_RRC, ebalu_pkg::ACT_RRCA: begin
        sh_c = v[0];
        sh_r = {v[0], v[7:1]};
      end
      ebalu_pkg::ACT_RL, ebalu_pkg::ACT_RLA: begin
        sh_c = v[7];
        sh_r = {v[6:0], cin};
      end
      ebalu_pkg::ACT_RR, ebalu_pkg::ACT_RRA: begin
        sh_c = v[0];
        sh_r = {cin, v[7:1]};
      end
      ebalu_pkg::ACT_SLA: begin
        sh_c = v[7];
        sh_r = {v[6:0], 1'b0};
      end
      ebalu_pkg::ACT_SRA: begin
        sh_c = v[0];
        sh_r = {v[7], v[7:1]};
      end
      ebalu_pkg::ACT_SWAP: begin
        sh_c = 1'b0;
        sh_r = {v[3:0], v[7:4]};
      end
      default: begin
        sh_c = v[0];
        sh_r = {1'b0, v[7:1]};
      end
    endcase
  end

  always_comb begin
    res.result      = 8'd0;
    res.flags_out   = item.flags_in;
    res.writes_back = 1'b1;
    case (item.action)
      ebalu_pkg::ACT_ADD, ebalu_pkg::ACT_ADC: begin
        res.result    = sum9[7:0];
        res.flags_out = '{ebalu_pkg::zflag(sum9[7:0]), 1'b0, hsum[4], sum9[8]};
      end
      ebalu_pkg::ACT_SUB, ebalu_pkg::ACT_SBC, ebalu_pkg::ACT_CP: begin
        res.result      = dif9[7:0];
        res.flags_out   = '{ebalu_pkg::zflag(dif9[7:0]), 1'b1, hdif[4], dif9[8]};
        res.writes_back = (item.action != ebalu_pkg::ACT_CP);
      end
      ebalu_pkg::ACT_AND: begin
        res.result    = a & v;
        res.flags_out = '{ebalu_pkg::zflag(a & v), 1'b0, 1'b1, 1'b0};
      end
      ebalu_pkg::ACT_XOR: begin
        res.result    = a ^ v;
        res.flags_out = '{ebalu_pkg::zflag(a ^ v), 1'b0, 1'b0, 1'b0};
      end
      ebalu_pkg::ACT_OR: begin
        res.result    = a | v;
        res.flags_out = '{ebalu_pkg::zflag(a | v), 1'b0, 1'b0, 1'b0};
      end
      ebalu_pkg::ACT_INC: begin
        res.result    = inc_v;
        res.flags_out = '{ebalu_pkg::zflag(inc_v), 1'b0, (inc_v[3:0] == 4'd0), cin};
      end
      ebalu_pkg::ACT_DEC: begin
        res.result    = dec_v;
        res.flags_out = '{ebalu_pkg::zflag(dec_v), 1'b1, (v[3:0] == 4'd0), cin};
      end
      ebalu_pkg::ACT_RLC, ebalu_pkg::ACT_RRC, ebalu_pkg::ACT_RL, ebalu_pkg::ACT_RR,
      ebalu_pkg::ACT_SLA, ebalu_pkg::ACT_SRA, ebalu_pkg::ACT_SWAP,
      ebalu_pkg::ACT_SRL: begin
        res.result    = sh_r;
        res.flags_out = '{ebalu_pkg::zflag(sh_r), 1'b0, 1'b0, sh_c};
      end
      ebalu_pkg::ACT_RLCA, ebalu_pkg::ACT_RRCA, ebalu_pkg::ACT_RLA,
      ebalu_pkg::ACT_RRA: begin
        res.result    = sh_r;
        res.flags_out = '{1'b0, 1'b0, 1'b0, sh_c};
      end
      ebalu_pkg::ACT_BIT: begin
        res.writes_back = 1'b0;
        res.flags_out   = '{!v[b], 1'b0, 1'b1, cin};
      end
      ebalu_pkg::ACT_RES: begin
        res.result = v & ~bmask;
      end
      ebalu_pkg::ACT_SET: begin
        res.result = v | bmask;
      end
      ebalu_pkg::ACT_DAA: begin
        res.result    = daa_r;
        res.flags_out = '{ebalu_pkg::zflag(daa_r), fn, 1'b0, daa_c};
      end
      ebalu_pkg::ACT_CPL: begin
        res.result    = ~a;
        res.flags_out = '{item.flags_in.z, 1'b1, 1'b1, cin};
      end
      ebalu_pkg::ACT_SCF: begin
        res.writes_back = 1'b0;
        res.flags_out   = '{item.flags_in.z, 1'b0, 1'b0, 1'b1};
      end
      ebalu_pkg::ACT_CCF: begin
        res.writes_back = 1'b0;
        res.flags_out   = '{item.flags_in.z, 1'b0, 1'b0, !cin};
      end
      default: begin
        res.writes_back = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/eight_bit_alu_with_flags.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags
// Stateless 8-bit ALU with Z/N/H/C flags on stream channels.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one operation per transfer (opcode, accumulator, operand,
//           bit index, current flags packed in in_tdata).
//   out_* : one result per transfer (result byte, new flags, write-back).
//   Path: input register, combinational core, result register, out_tdata.
//   Throughput: one operation per cycle while out_tready stays high; the
//   input register and the result register form a two-stage pipeline and
//   both load in the same cycle.
//   Stall: while out_tready is low the result register holds; the input
//   register still takes one more item, then in_tready drops until the
//   result is taken.
//   Reset: a synchronous rst_n low empties both stages, which leaves
//   in_tready high once reset is released.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [4:0] action, [12:5] acc_value, [20:13] operand_value,
  // [23:21] bit_index, [27:24] flags_in, [31:28] zero
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] result, [11:8] flags_out, [12] writes_back, [15:13] zero
  output logic [15:0] out_tdata
);

  ebalu_pkg::item_t item_r;
  logic             item_vld_r;
  ebalu_pkg::res_t  res;
  ebalu_pkg::res_t  res_r;
  logic             res_vld_r;
  logic             res_rdy;
  logic             item_rdy;

  assign res_rdy   = !res_vld_r || out_tready;
  assign item_rdy  = !item_vld_r || res_rdy;
  assign in_tready = item_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (item_rdy) begin
        item_vld_r <= in_tvalid;
      end
      if (res_rdy) begin
        res_vld_r <= item_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_rdy && in_tvalid) begin
      item_r <= ebalu_pkg::item_t'(in_tdata[ebalu_pkg::IN_BITS-1:0]);
    end
    if (res_rdy && item_vld_r) begin
      res_r <= res;
    end
  end

  ebalu_core u_core (
    .item (item_r),
    .res  (res)
  );

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {3'd0, res_r};

endmodule

// ===== rtl/ebalu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebalu_checker
// Port-level checks of the ALU stream channels, bound to the top level.
// ----------------------------------------------------------------------------
module ebalu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  // input side only blocks when both stages are full and the output stalls
  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");

endmodule

bind eight_bit_alu_with_flags ebalu_checker u_ebalu_chk (.*);

// ===== dv/tb_eight_bit_alu_with_flags.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eight_bit_alu_with_flags
// Streams operations through the eight-bit ALU and checks every result
// transfer, field by field, against the directed table or an in-bench
// model of the ALU. A short table of directed cases comes first, then
// random operations over all 32 opcode values. Both sides idle at random in
// phases, and one long output stall backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_eight_bit_alu_with_flags;

  localparam int unsigned RANDOM_OPS   = 1850;
  localparam int unsigned DIR_ROWS     = 31;
  localparam int unsigned STALL_AT     = 1400;
  localparam int unsigned STALL_CYCLES = 300;
  localparam logic [4:0]  ACT_UNUSED_TOP = 5'd31;

  typedef struct packed {
    logic             typed;
    ebalu_pkg::res_t  want;
    ebalu_pkg::item_t op;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  ebalu_pkg::res_t pending_results[$];
  int unsigned errors = 0;
  int unsigned results_checked = 0;
  int unsigned ops_sent = 0;
  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 59;
  int unsigned results_taken = 0;
  int unsigned stall_left = 0;
  logic        stall_done = 1'b0;

  always #4 clk = ~clk;

  eight_bit_alu_with_flags u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic ebalu_pkg::res_t alu_result_of(input ebalu_pkg::item_t op);
    logic [7:0] a, v, r, adj;
    logic [8:0] wide;
    logic [4:0] half;
    logic       ci, cy, wb, rot;
    ebalu_pkg::flags_t fi, fo;
    ebalu_pkg::res_t   res;
    a   = op.acc_value;
    v   = op.operand_value;
    fi  = op.flags_in;
    r   = 8'd0;
    fo  = fi;
    wb  = 1'b1;
    cy  = 1'b0;
    rot = 1'b0;
    ci  = 1'b0;
    case (op.action)
      ebalu_pkg::ACT_ADD, ebalu_pkg::ACT_ADC: begin
        ci   = (op.action == ebalu_pkg::ACT_ADC) ? fi.c : 1'b0;
        wide = {1'b0, a} + {1'b0, v} + {8'd0, ci};
        half = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, ci};
        r    = wide[7:0];
        fo   = {r == 8'd0, 1'b0, half[4], wide[8]};
      end
      ebalu_pkg::ACT_SUB, ebalu_pkg::ACT_SBC, ebalu_pkg::ACT_CP: begin
        ci   = (op.action == ebalu_pkg::ACT_SBC) ? fi.c : 1'b0;
        wide = {1'b0, a} - {1'b0, v} - {8'd0, ci};
        half = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, ci};
        r    = wide[7:0];
        fo   = {r == 8'd0, 1'b1, half[4], wide[8]};
        wb   = (op.action != ebalu_pkg::ACT_CP);
      end
      ebalu_pkg::ACT_AND: begin
        r  = a & v;
        fo = {r == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      ebalu_pkg::ACT_XOR: begin
        r  = a ^ v;
        fo = {r == 8'd0, 3'b000};
      end
      ebalu_pkg::ACT_OR: begin
        r  = a | v;
        fo = {r == 8'd0, 3'b000};
      end
      ebalu_pkg::ACT_INC: begin
        r  = v + 8'd1;
        fo = {r == 8'd0, 1'b0, r[3:0] == 4'd0, fi.c};
      end
      ebalu_pkg::ACT_DEC: begin
        r  = v - 8'd1;
        fo = {r == 8'd0, 1'b1, v[3:0] == 4'd0, fi.c};
      end
      ebalu_pkg::ACT_RLC, ebalu_pkg::ACT_RLCA: begin
        rot = 1'b1; cy = v[7]; r = {v[6:0], v[7]};
      end
      ebalu_pkg::ACT_RRC, ebalu_pkg::ACT_RRCA: begin
        rot = 1'b1; cy = v[0]; r = {v[0], v[7:1]};
      end
      ebalu_pkg::ACT_RL, ebalu_pkg::ACT_RLA: begin
        rot = 1'b1; cy = v[7]; r = {v[6:0], fi.c};
      end
      ebalu_pkg::ACT_RR, ebalu_pkg::ACT_RRA: begin
        rot = 1'b1; cy = v[0]; r = {fi.c, v[7:1]};
      end
      ebalu_pkg::ACT_SLA: begin
        rot = 1'b1; cy = v[7]; r = {v[6:0], 1'b0};
      end
      ebalu_pkg::ACT_SRA: begin
        rot = 1'b1; cy = v[0]; r = {v[7], v[7:1]};
      end
      ebalu_pkg::ACT_SWAP: begin
        rot = 1'b1; cy = 1'b0; r = {v[3:0], v[7:4]};
      end
      ebalu_pkg::ACT_SRL: begin
        rot = 1'b1; cy = v[0]; r = {1'b0, v[7:1]};
      end
      ebalu_pkg::ACT_BIT: begin
        wb = 1'b0;
        fo = {~v[op.bit_index], 1'b0, 1'b1, fi.c};
      end
      ebalu_pkg::ACT_RES: r = v & ~(8'd1 << op.bit_index);
      ebalu_pkg::ACT_SET: r = v | (8'd1 << op.bit_index);
      ebalu_pkg::ACT_DAA: begin
        adj = 8'd0;
        if (fi.h || (!fi.n && a[3:0] > ebalu_pkg::DIGIT_LIMIT)) adj = ebalu_pkg::DAA_ADJ_LO;
        if (fi.c || (!fi.n && a > ebalu_pkg::DAA_LIMIT)) begin
          adj = adj | ebalu_pkg::DAA_ADJ_HI;
          cy  = 1'b1;
        end
        r  = fi.n ? a - adj : a + adj;
        fo = {r == 8'd0, fi.n, 1'b0, cy};
      end
      ebalu_pkg::ACT_CPL: begin
        r  = ~a;
        fo = {fi.z, 1'b1, 1'b1, fi.c};
      end
      ebalu_pkg::ACT_SCF: begin
        wb = 1'b0;
        fo = {fi.z, 3'b001};
      end
      ebalu_pkg::ACT_CCF: begin
        wb = 1'b0;
        fo = {fi.z, 2'b00, ~fi.c};
      end
      default: begin
        wb = 1'b0;
        fo = fi;
      end
    endcase
    // accumulator rotates never set Z
    if (rot) fo = {(r == 8'd0) && (op.action < ebalu_pkg::ACT_RLCA), 2'b00, cy};
    res.result      = r;
    res.flags_out   = fo;
    res.writes_back = wb;
    return res;
  endfunction

  task automatic send_op(input ebalu_pkg::item_t op, input ebalu_pkg::res_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'h0, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(want);
    ops_sent++;
  endtask

  // receiver: random back-pressure plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) results_taken <= results_taken + 1;
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (!stall_done && results_taken == STALL_AT) begin
        stall_left <= STALL_CYCLES;
        stall_done <= 1'b1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    ebalu_pkg::res_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = ebalu_pkg::res_t'(out_tdata[12:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer %h", $time, out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.result !== want.result) begin
          $display("%0t: result exp %h got %h", $time, want.result, got.result);
          errors++;
        end
        if (got.flags_out !== want.flags_out) begin
          $display("%0t: flags exp %b got %b", $time, want.flags_out, got.flags_out);
          errors++;
        end
        if (got.writes_back !== want.writes_back) begin
          $display("%0t: write-back exp %b got %b", $time, want.writes_back,
                   got.writes_back);
          errors++;
        end
        if (out_tdata[15:13] !== 3'b000) begin
          $display("%0t: pad bits exp 000 got %b", $time, out_tdata[15:13]);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    dir_row_t         dir_table [DIR_ROWS];
    ebalu_pkg::item_t op;
    int unsigned      pick;
    // columns: typed, {wb, flags, result}, {flags, bit, operand, acc, action}
    dir_table = '{
      {1'b1, {1'b1, 4'hB, 8'h00}, {4'h0, 3'd0, 8'h01, 8'hFF, ebalu_pkg::ACT_ADD}},
      {1'b1, {1'b1, 4'h2, 8'h10}, {4'h1, 3'd0, 8'h00, 8'h0F, ebalu_pkg::ACT_ADC}},
      {1'b1, {1'b1, 4'h7, 8'hFF}, {4'h0, 3'd0, 8'h01, 8'h00, ebalu_pkg::ACT_SUB}},
      {1'b1, {1'b1, 4'hE, 8'h00}, {4'h1, 3'd0, 8'h0F, 8'h10, ebalu_pkg::ACT_SBC}},
      {1'b1, {1'b1, 4'hA, 8'h00}, {4'hF, 3'd0, 8'h00, 8'hFF, ebalu_pkg::ACT_AND}},
      {1'b1, {1'b1, 4'h0, 8'hFF}, {4'hF, 3'd0, 8'h55, 8'hAA, ebalu_pkg::ACT_XOR}},
      {1'b1, {1'b1, 4'h8, 8'h00}, {4'hF, 3'd0, 8'h00, 8'h00, ebalu_pkg::ACT_OR}},
      {1'b1, {1'b0, 4'hC, 8'h00}, {4'h0, 3'd0, 8'h3C, 8'h3C, ebalu_pkg::ACT_CP}},
      {1'b1, {1'b1, 4'hB, 8'h00}, {4'h1, 3'd0, 8'hFF, 8'h00, ebalu_pkg::ACT_INC}},
      {1'b1, {1'b1, 4'h6, 8'hFF}, {4'h0, 3'd0, 8'h00, 8'h00, ebalu_pkg::ACT_DEC}},
      {1'b1, {1'b1, 4'h1, 8'h01}, {4'h0, 3'd0, 8'h80, 8'h00, ebalu_pkg::ACT_RLC}},
      {1'b1, {1'b1, 4'h1, 8'h80}, {4'h0, 3'd0, 8'h01, 8'h00, ebalu_pkg::ACT_RRC}},
      {1'b1, {1'b1, 4'h9, 8'h00}, {4'h0, 3'd0, 8'h80, 8'h00, ebalu_pkg::ACT_RL}},
      {1'b1, {1'b1, 4'h1, 8'h80}, {4'h1, 3'd0, 8'h01, 8'h00, ebalu_pkg::ACT_RR}},
      {1'b1, {1'b1, 4'h1, 8'hFE}, {4'h0, 3'd0, 8'hFF, 8'h00, ebalu_pkg::ACT_SLA}},
      {1'b1, {1'b1, 4'h1, 8'hC0}, {4'h0, 3'd0, 8'h81, 8'h00, ebalu_pkg::ACT_SRA}},
      {1'b1, {1'b1, 4'h0, 8'h0F}, {4'hF, 3'd0, 8'hF0, 8'h00, ebalu_pkg::ACT_SWAP}},
      {1'b1, {1'b1, 4'h9, 8'h00}, {4'h0, 3'd0, 8'h01, 8'h00, ebalu_pkg::ACT_SRL}},
      {1'b1, {1'b0, 4'hB, 8'h00}, {4'h1, 3'd7, 8'h7F, 8'h00, ebalu_pkg::ACT_BIT}},
      {1'b1, {1'b1, 4'h5, 8'hFE}, {4'h5, 3'd0, 8'hFF, 8'h00, ebalu_pkg::ACT_RES}},
      {1'b1, {1'b1, 4'hA, 8'h80}, {4'hA, 3'd7, 8'h00, 8'h00, ebalu_pkg::ACT_SET}},
      {1'b1, {1'b1, 4'h9, 8'h00}, {4'h0, 3'd0, 8'h00, 8'h9A, ebalu_pkg::ACT_DAA}},
      {1'b0, 13'h0,               {4'h6, 3'd0, 8'h00, 8'h45, ebalu_pkg::ACT_DAA}},
      {1'b1, {1'b1, 4'h6, 8'hFF}, {4'h0, 3'd0, 8'h00, 8'h00, ebalu_pkg::ACT_CPL}},
      {1'b1, {1'b0, 4'h9, 8'h00}, {4'hE, 3'd0, 8'h00, 8'h00, ebalu_pkg::ACT_SCF}},
      {1'b1, {1'b0, 4'h8, 8'h00}, {4'h9, 3'd0, 8'h00, 8'h00, ebalu_pkg::ACT_CCF}},
      {1'b1, {1'b1, 4'h0, 8'h00}, {4'h8, 3'd0, 8'h00, 8'h00, ebalu_pkg::ACT_RLCA}},
      {1'b0, 13'h0,               {4'h0, 3'd0, 8'h01, 8'h00, ebalu_pkg::ACT_RRCA}},
      {1'b0, 13'h0,               {4'h1, 3'd0, 8'h80, 8'h00, ebalu_pkg::ACT_RLA}},
      {1'b0, 13'h0,               {4'h1, 3'd0, 8'h00, 8'h00, ebalu_pkg::ACT_RRA}},
      {1'b1, {1'b0, 4'hF, 8'h00}, {4'hF, 3'd7, 8'hFF, 8'hFF, ACT_UNUSED_TOP}}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) begin
      op = dir_table[i].op;
      send_op(op, dir_table[i].typed ? dir_table[i].want : alu_result_of(op));
    end

    for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
      if (n == RANDOM_OPS / 3) begin
        send_idle_pct <= 59;
        recv_idle_pct <= 29;
      end else if (n == 2 * RANDOM_OPS / 3) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      pick = $urandom_range(0, 19);
      op.action        = ebalu_pkg::action_t'(5'((pick == 0)
                           ? $urandom_range(int'(ebalu_pkg::ACT_RRA) + 1, ACT_UNUSED_TOP)
                           : $urandom_range(0, int'(ebalu_pkg::ACT_RRA))));
      op.acc_value     = 8'($urandom_range(0, 255));
      op.operand_value = 8'($urandom_range(0, 255));
      op.bit_index     = 3'($urandom_range(0, 7));
      op.flags_in      = ebalu_pkg::flags_t'(4'($urandom_range(0, 15)));
      send_op(op, alu_result_of(op));
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d operations (%0d from the directed table), all 32 opcodes;",
             ops_sent, DIR_ROWS);
    $display("checked %0d results under random idling and a %0d-cycle output stall.",
             results_checked, STALL_CYCLES);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
